// ===== hw/rtl/falc_pkg.sv =====
`timescale 1ns / 1ps

package falc_pkg;

  // Cache geometry
  localparam int LINES        = 512;
  localparam int OFFSET_BITS  = 6;
  localparam int ADDRESS_BITS = 48;

  // Derived widths
  localparam int TAG_W = ADDRESS_BITS - OFFSET_BITS;
  localparam int IDX_W = $clog2(LINES);
  localparam int CNT_W = $clog2(LINES + 1);
  localparam int STAT_W = 32;

  // Line count as a fill-count value
  localparam logic [CNT_W-1:0] LINES_C = CNT_W'(LINES);

endpackage

// ===== hw/rtl/falc_ram.sv =====
`timescale 1ns / 1ps

module falc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/fully_assoc_lru_cache_model_core.sv =====
`timescale 1ns / 1ps

// Fully associative cache model, 512 lines, LRU replacement.
// Input channel: present in_address with start high; the word is taken at a
// clock edge where start is high and busy is low. busy stays high while the
// access is worked on, so one access is in flight at a time.
// Result channel: out_valid is high for exactly one cycle with out_hit,
// out_evicted and the three saturating totals. The receiver cannot stall;
// the result must be taken in that cycle. The next access may be started in
// the same cycle the result is shown.
// Sequencing: one tag RAM read port scans the filled lines, one per cycle,
// until a match or past the last filled line. A hit on the newest line goes
// straight to ST_FINISH; any other hit and an evicting miss read the line's
// links (ST_LREAD, ST_LDATA) and unlink it, and every miss and moved hit is
// then appended at the newest end (ST_APP1, ST_APP2). The scan is the limiting
// loop; the recency list update works on its two link RAMs.
// Reset (rst_n low, synchronous) empties the cache through the fill count
// and clears all counters; no clearing pass of the RAMs is needed, since
// lines fill in index order and only filled lines are ever read.
module fully_assoc_lru_cache_model_core
  import falc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [ADDRESS_BITS-1:0] in_address,
  output logic                    out_valid,
  output logic                    out_hit,
  output logic                    out_evicted,
  output logic [STAT_W-1:0]       out_access_total,
  output logic [STAT_W-1:0]       out_miss_total,
  output logic [STAT_W-1:0]       out_hit_total
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SEARCH = 7'b0000010,
    ST_LREAD  = 7'b0000100,
    ST_LDATA  = 7'b0001000,
    ST_APP1   = 7'b0010000,
    ST_APP2   = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [TAG_W-1:0]  tag_r;
  logic [CNT_W-1:0]  scan_r;
  logic              cmp_vld_r;
  logic [IDX_W-1:0]  cmp_idx_r;
  logic [IDX_W-1:0]  p_r;
  logic              hit_r;
  logic              evict_r;
  logic [IDX_W-1:0]  oldest_r;
  logic [IDX_W-1:0]  newest_r;
  logic [CNT_W-1:0]  filled_r;
  logic [STAT_W-1:0] acc_cnt_r, miss_cnt_r, hit_cnt_r;
  logic [STAT_W-1:0] acc_cnt_nxt, miss_cnt_nxt, hit_cnt_nxt;
  logic              out_valid_r, out_hit_r, out_evicted_r;
  logic [STAT_W-1:0] out_acc_r, out_miss_r, out_hits_r;

  logic [TAG_W-1:0]  tag_rd;
  logic [IDX_W-1:0]  older_rd, newer_rd;
  logic              tag_we;
  logic              older_we, newer_we;
  logic [IDX_W-1:0]  older_waddr, older_wdata, newer_waddr, newer_wdata;
  logic              match;
  logic              scan_done;
  logic              accept;
  logic              unlink_mid;

  assign accept     = start && (state_r == ST_IDLE);
  assign match      = cmp_vld_r && (tag_rd == tag_r);
  assign scan_done  = !cmp_vld_r && (scan_r >= filled_r);
  assign unlink_mid = hit_r && (p_r != oldest_r);

  // Tag store: scanned during search, written once per miss
  assign tag_we = (state_r == ST_APP1) && !hit_r;

  falc_ram #(.WIDTH(TAG_W), .DEPTH(LINES)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (p_r),
    .wdata (tag_r),
    .raddr (scan_r[IDX_W-1:0]),
    .rdata (tag_rd)
  );

  // Recency links: steer the single write port of each link RAM
  always_comb begin
    older_we    = 1'b0;
    older_waddr = p_r;
    older_wdata = newest_r;
    newer_we    = 1'b0;
    newer_waddr = p_r;
    newer_wdata = p_r;
    case (state_r)
      ST_LDATA: begin
        if (unlink_mid) begin
          newer_we    = 1'b1;
          newer_waddr = older_rd;
          newer_wdata = newer_rd;
          older_we    = 1'b1;
          older_waddr = newer_rd;
          older_wdata = older_rd;
        end
      end
      ST_APP1: begin
        newer_we    = 1'b1;
        newer_waddr = newest_r;
        newer_wdata = p_r;
        older_we    = 1'b1;
        older_waddr = p_r;
        older_wdata = newest_r;
      end
      ST_APP2: begin
        newer_we    = 1'b1;
        newer_waddr = p_r;
        newer_wdata = p_r;
      end
      default: begin
      end
    endcase
  end

  falc_ram #(.WIDTH(IDX_W), .DEPTH(LINES)) u_older_ram (
    .clk   (clk),
    .we    (older_we),
    .waddr (older_waddr),
    .wdata (older_wdata),
    .raddr (p_r),
    .rdata (older_rd)
  );

  falc_ram #(.WIDTH(IDX_W), .DEPTH(LINES)) u_newer_ram (
    .clk   (clk),
    .we    (newer_we),
    .waddr (newer_waddr),
    .wdata (newer_wdata),
    .raddr (p_r),
    .rdata (newer_rd)
  );

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (match) begin
          state_nxt = (cmp_idx_r == newest_r) ? ST_FINISH : ST_LREAD;
        end else if (scan_done) begin
          state_nxt = (filled_r == LINES_C) ? ST_LREAD : ST_APP1;
        end
      end
      ST_LREAD:  state_nxt = ST_LDATA;
      ST_LDATA:  state_nxt = ST_APP1;
      ST_APP1:   state_nxt = ST_APP2;
      ST_APP2:   state_nxt = ST_FINISH;
      ST_FINISH: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Saturating counter updates
  always_comb begin
    acc_cnt_nxt  = (acc_cnt_r == '1) ? acc_cnt_r : acc_cnt_r + 1'b1;
    miss_cnt_nxt = miss_cnt_r;
    hit_cnt_nxt  = hit_cnt_r;
    if (hit_r) begin
      hit_cnt_nxt = (hit_cnt_r == '1) ? hit_cnt_r : hit_cnt_r + 1'b1;
    end else begin
      miss_cnt_nxt = (miss_cnt_r == '1) ? miss_cnt_r : miss_cnt_r + 1'b1;
    end
  end

  // Control and list-end registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cmp_vld_r   <= 1'b0;
      scan_r      <= '0;
      oldest_r    <= '0;
      newest_r    <= '0;
      filled_r    <= '0;
      acc_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      hit_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      hit_r       <= 1'b0;
      evict_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          scan_r    <= '0;
          cmp_vld_r <= 1'b0;
          hit_r     <= 1'b0;
          evict_r   <= 1'b0;
        end
        ST_SEARCH: begin
          // advance the scan one line per cycle; each line is compared in the next cycle
          cmp_vld_r <= (scan_r < filled_r);
          if (scan_r < filled_r) scan_r <= scan_r + 1'b1;
          if (match) begin
            hit_r <= 1'b1;
          end else if (scan_done && (filled_r == LINES_C)) begin
            evict_r <= 1'b1;
          end
        end
        ST_LDATA: begin
          // drop the line from its place; the oldest end moves if it was there
          if (!unlink_mid) oldest_r <= newer_rd;
        end
        ST_APP1: begin
          if (!hit_r && !evict_r) begin
            if (filled_r == '0) oldest_r <= p_r;
            filled_r <= filled_r + 1'b1;
          end
        end
        ST_APP2: begin
          newest_r <= p_r;
        end
        ST_FINISH: begin
          acc_cnt_r   <= acc_cnt_nxt;
          miss_cnt_r  <= miss_cnt_nxt;
          hit_cnt_r   <= hit_cnt_nxt;
          out_valid_r <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) tag_r <= in_address[ADDRESS_BITS-1:OFFSET_BITS];
    if (state_r == ST_SEARCH) begin
      cmp_idx_r <= scan_r[IDX_W-1:0];
      if (match) begin
        p_r <= cmp_idx_r;
      end else if (scan_done) begin
        p_r <= (filled_r == LINES_C) ? oldest_r : filled_r[IDX_W-1:0];
      end
    end
    if (state_r == ST_FINISH) begin
      out_hit_r     <= hit_r;
      out_evicted_r <= evict_r;
      out_acc_r     <= acc_cnt_nxt;
      out_miss_r    <= miss_cnt_nxt;
      out_hits_r    <= hit_cnt_nxt;
    end
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_evicted      = out_evicted_r;
  assign out_access_total = out_acc_r;
  assign out_miss_total   = out_miss_r;
  assign out_hit_total    = out_hits_r;

endmodule

// ===== dv/fully_assoc_lru_cache_model_core_test.sv =====
`timescale 1ns / 1ps

module fully_assoc_lru_cache_model_core_test
  import falc_pkg::*;
();

  // Longest quiet stretch in a correct run: a full scan plus list update
  // and the longest sender gap, taken about five times over.
  localparam int IDLE_CAP    = 40;
  localparam int STALL_LIMIT = 3000;
  localparam int TAIL_CYCLES = 600;
  localparam int MAX_PRINTS  = 40;
  localparam int DISPLACED_KEEP = 64;

  typedef struct {
    int unsigned             seq;
    logic [ADDRESS_BITS-1:0] address;
    logic                    hit;
    logic                    evicted;
    logic [STAT_W-1:0]       accesses;
    logic [STAT_W-1:0]       misses;
    logic [STAT_W-1:0]       hits;
  } access_outcome_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [ADDRESS_BITS-1:0] in_address = '0;
  logic                    out_valid;
  logic                    out_hit;
  logic                    out_evicted;
  logic [STAT_W-1:0]       out_access_total;
  logic [STAT_W-1:0]       out_miss_total;
  logic [STAT_W-1:0]       out_hit_total;

  // Mirror of the cache contents and recency list
  logic [TAG_W-1:0]  tag_mirror [LINES];
  bit                valid_mirror [LINES];
  logic [IDX_W-1:0]  older_mirror [LINES];
  logic [IDX_W-1:0]  newer_mirror [LINES];
  logic [IDX_W-1:0]  lru_line = '0;
  logic [IDX_W-1:0]  mru_line = '0;
  logic [CNT_W-1:0]  fill_count = '0;
  logic [STAT_W-1:0] access_tally = '0;
  logic [STAT_W-1:0] miss_tally = '0;
  logic [STAT_W-1:0] hit_tally = '0;
  logic [TAG_W-1:0]  displaced_tags [$];

  access_outcome_t expected_outcomes [$];
  int unsigned     words_sent = 0;
  int              error_count = 0;
  int              idle_pct = 0;
  int              quiet_cycles = 0;

  fully_assoc_lru_cache_model_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_address       (in_address),
    .out_valid        (out_valid),
    .out_hit          (out_hit),
    .out_evicted      (out_evicted),
    .out_access_total (out_access_total),
    .out_miss_total   (out_miss_total),
    .out_hit_total    (out_hit_total)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Print one line per failure, with a cap on the printout
  task automatic log_error(input string msg);
    if (error_count < MAX_PRINTS) $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic compare_field(input string field, input access_outcome_t want,
                               input logic [STAT_W-1:0] exp_v,
                               input logic [STAT_W-1:0] got_v);
    if (got_v !== exp_v)
      log_error($sformatf("access %0d addr %h: %s expected %0h got %0h",
                          want.seq, want.address, field, exp_v, got_v));
  endtask

  // Saturating counter step; saturation itself needs 2^32 - 1 accesses
  function automatic logic [STAT_W-1:0] bump(input logic [STAT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Link line p behind the newest line and make it the newest
  task automatic relink_newest(input logic [IDX_W-1:0] p);
    older_mirror[p] = mru_line;
    newer_mirror[mru_line] = p;
    newer_mirror[p] = p;
    mru_line = p;
  endtask

  // Look up one address, update the mirror and return the outcome
  task automatic cache_lookup(input logic [ADDRESS_BITS-1:0] addr,
                              output access_outcome_t res);
    logic [TAG_W-1:0] tag;
    logic [IDX_W-1:0] p;
    logic [IDX_W-1:0] od;
    logic [IDX_W-1:0] nw;
    int               way;
    int               i;
    tag = addr[ADDRESS_BITS-1:OFFSET_BITS];
    way = -1;
    for (i = 0; i < LINES; i++)
      if (way < 0 && valid_mirror[i] && tag_mirror[i] == tag) way = i;
    res.seq = words_sent;
    res.address = addr;
    res.hit = (way >= 0);
    res.evicted = 1'b0;
    if (way >= 0) begin
      // hit: move the line to the newest end unless it is there already
      p = IDX_W'(way);
      if (p != mru_line) begin
        nw = newer_mirror[p];
        if (p == lru_line) begin
          lru_line = nw;
        end else begin
          od = older_mirror[p];
          newer_mirror[od] = nw;
          older_mirror[nw] = od;
        end
        relink_newest(p);
      end
      hit_tally = bump(hit_tally);
    end else begin
      if (fill_count < LINES_C) begin
        // fill the next unused line
        p = fill_count[IDX_W-1:0];
        tag_mirror[p] = tag;
        valid_mirror[p] = 1'b1;
        if (fill_count == 0) begin
          lru_line = p;
          mru_line = p;
          older_mirror[p] = p;
          newer_mirror[p] = p;
        end else begin
          relink_newest(p);
        end
        fill_count++;
      end else begin
        // replace the least recently used line
        p = lru_line;
        lru_line = newer_mirror[p];
        displaced_tags.push_back(tag_mirror[p]);
        if (displaced_tags.size() > DISPLACED_KEEP) void'(displaced_tags.pop_front());
        tag_mirror[p] = tag;
        relink_newest(p);
        res.evicted = 1'b1;
      end
      miss_tally = bump(miss_tally);
    end
    access_tally = bump(access_tally);
    res.accesses = access_tally;
    res.misses = miss_tally;
    res.hits = hit_tally;
  endtask

  // Present one word and hold it until taken
  task automatic send_access(input logic [ADDRESS_BITS-1:0] addr);
    access_outcome_t outcome;
    start <= 1'b1;
    in_address <= addr;
    do @(posedge clk); while (busy);
    cache_lookup(addr, outcome);
    expected_outcomes.push_back(outcome);
    words_sent++;
  endtask

  // Drop start for a random number of cycles
  task automatic idle_gap();
    int gap;
    if ($urandom_range(99) >= idle_pct) return;
    gap = 1;
    while (gap < IDLE_CAP && $urandom_range(99) < idle_pct) gap++;
    start <= 1'b0;
    in_address <= ADDRESS_BITS'({$urandom, $urandom});
    repeat (gap) @(posedge clk);
  endtask

  // Hold off the sender until every outstanding result has come back
  task automatic wait_for_results();
    while (expected_outcomes.size() != 0) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Choose an address: a fresh tag, a recently displaced tag, or a resident
  // line, at random or near either end of the recency list
  function automatic logic [ADDRESS_BITS-1:0] pick_address(input int fresh_pct);
    logic [IDX_W-1:0] p;
    if (fill_count == 0 || $urandom_range(99) < fresh_pct) begin
      if (displaced_tags.size() != 0 && $urandom_range(2) == 0)
        return {displaced_tags[$urandom_range(displaced_tags.size() - 1)],
                OFFSET_BITS'($urandom)};
      return ADDRESS_BITS'({$urandom, $urandom});
    end
    case ($urandom_range(3))
      0: p = IDX_W'($urandom_range(int'(fill_count) - 1));
      1: p = lru_line;
      2: p = mru_line;
      default: p = newer_mirror[lru_line];
    endcase
    return {tag_mirror[p], OFFSET_BITS'($urandom)};
  endfunction

  task automatic run_accesses(input int count, input int fresh_pct, input int drain_odds);
    int n;
    for (n = 0; n < count; n++) begin
      send_access(pick_address(fresh_pct));
      if (drain_odds > 0 && $urandom_range(drain_odds - 1) == 0) wait_for_results();
      else idle_gap();
    end
  endtask

  // Tag zero, all-ones tags, offset-only changes, hits at both list ends
  task automatic test_directed();
    logic [ADDRESS_BITS-1:0] seq_addr [20] = '{
      48'h0000_0000_0000, 48'h0000_0000_003F, 48'hFFFF_FFFF_FFFF,
      48'hFFFF_FFFF_FFC0, 48'h0000_0000_0040, 48'h0000_0000_0000,
      48'hFFFF_FFFF_FFFF, 48'h0000_0000_0020, 48'h8000_0000_0000,
      48'h0000_0000_0001, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555,
      48'h5555_5555_5540, 48'hAAAA_AAAA_AA80, 48'h0000_0000_007F,
      48'hFFFF_FFFF_FFBF, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_003F,
      48'h0000_0000_0000, 48'h7FFF_FFFF_FFC0};
    idle_pct = 0;
    foreach (seq_addr[k]) send_access(seq_addr[k]);
  endtask

  // Mostly fresh tags back to back to fill a large part of the store
  task automatic test_fill_back_to_back();
    idle_pct = 0;
    run_accesses(320, 95, 0);
  endtask

  // Mostly fresh tags and resident hits under heavy sender gaps
  task automatic test_lru_with_sender_gaps();
    idle_pct = 57;
    run_accesses(250, 75, 0);
  endtask

  // Restart from an idle block, then mixed traffic with occasional drains
  task automatic test_lru_after_drain();
    wait_for_results();
    idle_pct = 10;
    run_accesses(250, 60, 40);
  endtask

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    access_outcome_t want;
    if (rst_n && out_valid) begin
      if (expected_outcomes.size() == 0) begin
        log_error("result with no access outstanding");
      end else begin
        want = expected_outcomes.pop_front();
        compare_field("hit", want, STAT_W'(want.hit), STAT_W'(out_hit));
        compare_field("evicted", want, STAT_W'(want.evicted), STAT_W'(out_evicted));
        compare_field("access_total", want, want.accesses, out_access_total);
        compare_field("miss_total", want, want.misses, out_miss_total);
        compare_field("hit_total", want, want.hits, out_hit_total);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("ERROR: no word moved for %0d cycles", STALL_LIMIT);
      $display("** fully_assoc_lru_cache_model_core: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_fill_back_to_back();
    test_lru_with_sender_gaps();
    test_lru_after_drain();
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("** fully_assoc_lru_cache_model_core: PASSED **");
    end else begin
      $display("** fully_assoc_lru_cache_model_core: FAILED **");
    end
    $finish;
  end

endmodule
